FILE: rtl/core/lrsv_pkg.sv
`default_nettype none
package lrsv_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int SIZE_W          = 24;
    localparam int COUNT_W         = 24;

    // parse phases
    localparam logic [2:0] PH_TYPE    = 3'd0;
    localparam logic [2:0] PH_LEN_HI  = 3'd1;
    localparam logic [2:0] PH_LEN_LO  = 3'd2;
    localparam logic [2:0] PH_ADR_HI  = 3'd3;
    localparam logic [2:0] PH_ADR_LO  = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;

    // verdict codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_TRUNC   = 3'd1;
    localparam logic [2:0] ST_WRAP    = 3'd2;
    localparam logic [2:0] ST_MAILBOX = 3'd3;
    localparam logic [2:0] ST_LOADER  = 3'd4;
    localparam logic [2:0] ST_BADLEN  = 3'd5;
    localparam logic [2:0] ST_BADREC  = 3'd6;
    localparam logic [2:0] ST_MISSING = 3'd7;

    localparam logic [7:0]  KIND_DATA   = 8'h00;
    localparam logic [7:0]  KIND_END    = 8'hff;
    localparam logic [16:0] ADDR_LIMIT  = 17'h10000;
    localparam logic [15:0] MAILBOX_LO  = 16'hff62;
    localparam logic [15:0] MAILBOX_HI  = 16'hff64;
    localparam logic [15:0] LOADER_LO   = 16'hfe00;
    localparam logic [15:0] LOADER_HI   = 16'hfeff;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
    } item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [15:0]        entry_addr;
        logic [COUNT_W-1:0] payload_total;
        logic [COUNT_W-1:0] consumed_total;
        logic [COUNT_W-1:0] record_total;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/lrsv_step.sv
`default_nettype none
module lrsv_step #(
    parameter int OFFSET_BITS = lrsv_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step_valid,
    input  wire lrsv_pkg::item_t             step_item,
    input  wire logic [lrsv_pkg::SIZE_W-1:0] size_limit,
    output logic                             res_valid,
    output lrsv_pkg::result_t                res
);
    import lrsv_pkg::*;

    localparam int CMP_W = (OFFSET_BITS > SIZE_W) ? OFFSET_BITS : SIZE_W;

    logic [2:0]             phase_reg, phase_next;
    logic [7:0]             kind_reg, kind_next;
    logic [15:0]            len_reg, len_next;
    logic [7:0]             adrh_reg, adrh_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [15:0]            left_reg, left_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [COUNT_W-1:0]     total_reg, total_next;

    logic [OFFSET_BITS-1:0] offset_inc;
    logic [CMP_W-1:0]       offset_ext, offset_inc_ext, size_ext, len_ext;
    logic [15:0]            addr, left_dec;
    logic [16:0]            span_end, span_last;
    logic                   len_nz, hit_mailbox, hit_loader, bad_len;
    logic                   verdict;
    logic [2:0]             status;

    always_comb
    begin
        offset_inc     = offset_reg + 1'b1;
        offset_ext     = CMP_W'(offset_reg);
        offset_inc_ext = CMP_W'(offset_inc);
        size_ext       = CMP_W'(size_limit);
        len_ext        = CMP_W'(len_reg);
        addr           = {adrh_reg, step_item.byte_value};
        span_end       = {1'b0, addr} + {1'b0, len_reg};
        span_last      = span_end - 17'd1;
        len_nz         = (len_reg != 16'd0);
        hit_mailbox    = len_nz && (addr <= MAILBOX_HI) && (span_last >= {1'b0, MAILBOX_LO});
        hit_loader     = len_nz && (addr <= LOADER_HI) && (span_last >= {1'b0, LOADER_LO});
        // room left after this byte counts as zero once the size is reached
        if (offset_inc_ext < size_ext)
        begin
            bad_len = len_ext > (size_ext - offset_inc_ext);
        end
        else
        begin
            bad_len = len_nz;
        end
        left_dec = left_reg - 16'd1;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        len_next    = len_reg;
        adrh_next   = adrh_reg;
        offset_next = offset_reg;
        left_next   = left_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        verdict     = 1'b0;
        status      = ST_OK;

        if (step_item.kind || (offset_ext >= size_ext))
        begin
            verdict = 1'b1;
            status  = ST_TRUNC;
        end
        else
        begin
            offset_next = offset_inc;
            unique case (phase_reg)
                PH_TYPE:
                begin
                    kind_next  = step_item.byte_value;
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len_next   = {step_item.byte_value, 8'h00};
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next   = {len_reg[15:8], step_item.byte_value};
                    phase_next = PH_ADR_HI;
                end
                PH_ADR_HI:
                begin
                    adrh_next  = step_item.byte_value;
                    phase_next = PH_ADR_LO;
                end
                PH_ADR_LO:
                begin
                    if (kind_reg == KIND_DATA)
                    begin
                        if (span_end > ADDR_LIMIT)
                        begin
                            verdict = 1'b1;
                            status  = ST_WRAP;
                        end
                        else if (hit_mailbox)
                        begin
                            verdict = 1'b1;
                            status  = ST_MAILBOX;
                        end
                        else if (hit_loader)
                        begin
                            verdict = 1'b1;
                            status  = ST_LOADER;
                        end
                        else if (bad_len)
                        begin
                            verdict = 1'b1;
                            status  = ST_BADLEN;
                        end
                        else if (!len_nz)
                        begin
                            count_next = count_reg + 1'b1;
                            phase_next = PH_TYPE;
                        end
                        else
                        begin
                            left_next  = len_reg;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        verdict = 1'b1;
                        if (kind_reg != KIND_END)
                        begin
                            status = ST_BADREC;
                        end
                        else if (count_reg == '0)
                        begin
                            status = ST_MISSING;
                        end
                        else if (addr >= MAILBOX_LO && addr <= MAILBOX_HI)
                        begin
                            status = ST_MAILBOX;
                        end
                        else if (addr >= LOADER_LO && addr <= LOADER_HI)
                        begin
                            status = ST_LOADER;
                        end
                        else
                        begin
                            status = ST_OK;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    left_next = left_dec;
                    if (left_dec == 16'd0)
                    begin
                        count_next = count_reg + 1'b1;
                        total_next = total_reg + COUNT_W'(len_reg);
                        phase_next = PH_TYPE;
                    end
                end
                default:
                begin
                    phase_next = PH_TYPE;
                end
            endcase
            // size used up with more bytes still needed
            if (!verdict && (offset_inc_ext >= size_ext))
            begin
                verdict = 1'b1;
                status  = ST_TRUNC;
            end
        end

        res_valid                 = step_valid && verdict;
        res.status                = status;
        res.entry_addr            = (status == ST_OK) ? addr : 16'd0;
        res.payload_total         = total_next;
        res.consumed_total        = (status == ST_OK) ? offset_inc_ext[COUNT_W-1:0] : '0;
        res.record_total          = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TYPE;
            kind_reg   <= '0;
            len_reg    <= '0;
            adrh_reg   <= '0;
            offset_reg <= '0;
            left_reg   <= '0;
            count_reg  <= '0;
            total_reg  <= '0;
        end
        else if (step_valid)
        begin
            if (verdict)
            begin
                phase_reg  <= PH_TYPE;
                kind_reg   <= '0;
                len_reg    <= '0;
                adrh_reg   <= '0;
                offset_reg <= '0;
                left_reg   <= '0;
                count_reg  <= '0;
                total_reg  <= '0;
            end
            else
            begin
                phase_reg  <= phase_next;
                kind_reg   <= kind_next;
                len_reg    <= len_next;
                adrh_reg   <= adrh_next;
                offset_reg <= offset_next;
                left_reg   <= left_next;
                count_reg  <= count_next;
                total_reg  <= total_next;
            end
        end
    end

    a_verdict_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (phase_reg == PH_TYPE && count_reg == '0 && offset_reg == '0))
        else $error("state not cleared after verdict");

    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (left_reg != 16'd0))
        else $error("payload phase with nothing left");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step_valid |=> ($stable(offset_reg) && $stable(count_reg) && $stable(phase_reg)))
        else $error("state moved without an item");

    a_ok_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == ST_OK) |-> (res.record_total != '0))
        else $error("ok verdict without data records");

endmodule
`default_nettype wire

FILE: rtl/core/load_record_stream_validator.sv
`default_nettype none
// channel  | handshake                   | payload
// ---------+-----------------------------+--------------------------
// item     | item_valid / item_ready     | item   (kind, byte_value)
// result   | result_valid / result_ready | result (verdict and counts)
// config   | cfg_we                      | cfg_wdata (size limit)
//
// one file byte per cycle while no result waits untaken; each item is registered,
// parsed combinationally against the record state, and a verdict lands in the
// result register, which loads as the registered item is stepped.
// while a result waits untaken the parse step holds; the input register
// takes at most one more byte, then item_ready stays low until the result transfer.
// reset clears the record state and the size register to zero.
module load_record_stream_validator #(
    parameter int OFFSET_BITS = lrsv_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    output logic                             item_ready,
    input  wire lrsv_pkg::item_t             item,
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output lrsv_pkg::result_t                result,
    input  wire logic                        cfg_we,
    input  wire logic [lrsv_pkg::SIZE_W-1:0] cfg_wdata
);
    import lrsv_pkg::*;

    logic              item_full_reg;
    item_t             item_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              step_go;
    logic              res_valid;
    result_t           res;

    assign step_go      = item_full_reg && (!out_valid_reg || result_ready);
    assign item_ready   = !item_full_reg || step_go;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    lrsv_step #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_valid(step_go),
        .step_item (item_reg),
        .size_limit(size_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_full_reg <= 1'b0;
        end
        else if (item_valid && item_ready)
        begin
            item_full_reg <= 1'b1;
        end
        else if (step_go)
        begin
            item_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    // result register: refill on a verdict, drain on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_go && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_go && res_valid)
        begin
            out_reg <= res;
        end
    end

endmodule
`default_nettype wire

FILE: bench/load_record_stream_validator_test.sv
`timescale 1ns / 100ps
module load_record_stream_validator_test;
    import lrsv_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_CYCLES  = 10;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_PERIODIC, RX_SPARSE} rx_mode_e;
    typedef enum int {
        F_NONE, F_WRAP, F_WRAP_FULL, F_MAILBOX, F_LOADER, F_BADLEN, F_BADTYPE, F_READFAIL
    } fault_e;

    class verdict_board;
        result_t pending[$];
        int errors;
        int matched;
        int status_hits[8];
        logic [SIZE_W-1:0]          size_limit;
        logic [2:0]                 phase;
        logic [7:0]                 rec_kind;
        logic [15:0]                hdr_len;
        logic [7:0]                 addr_hi;
        logic [OFFSET_BITS_DEF-1:0] offset;
        logic [15:0]                payload_left;
        logic [COUNT_W-1:0]         rec_count;
        logic [COUNT_W-1:0]         byte_sum;

        function new();
            size_limit = '0;
            errors = 0;
            matched = 0;
            foreach (status_hits[i])
                status_hits[i] = 0;
            clear_record();
        endfunction

        function void clear_record();
            phase = PH_TYPE;
            rec_kind = '0;
            hdr_len = '0;
            addr_hi = '0;
            offset = '0;
            payload_left = '0;
            rec_count = '0;
            byte_sum = '0;
        endfunction

        function void set_size(logic [SIZE_W-1:0] v);
            size_limit = v;
        endfunction

        function bit hits_span(logic [15:0] addr, logic [15:0] len,
                               logic [15:0] lo, logic [15:0] hi);
            logic [16:0] last;
            last = {1'b0, addr} + {1'b0, len} - 17'd1;
            return len != 16'd0 && addr <= hi && last >= {1'b0, lo};
        endfunction

        function result_t close(logic [2:0] st, logic [15:0] exec_addr);
            result_t r;
            r.status = st;
            r.entry_addr = (st == ST_OK) ? exec_addr : 16'h0000;
            r.payload_total = byte_sum;
            r.consumed_total = (st == ST_OK) ? COUNT_W'(offset) : '0;
            r.record_total = rec_count;
            clear_record();
            return r;
        endfunction

        function void accept_record();
            rec_count = rec_count + 1'b1;
            byte_sum = byte_sum + hdr_len;
            phase = PH_TYPE;
        endfunction

        // returns 1 when this transfer ends the file with a verdict
        function bit parse_byte(item_t it, output result_t r);
            logic [15:0]       addr;
            logic [SIZE_W-1:0] room;
            logic [2:0]        st;
            bit                done;
            r = '0;
            addr = '0;
            st = ST_OK;
            done = 1'b0;
            if (it.kind || offset >= size_limit)
            begin
                r = close(ST_TRUNC, '0);
                return 1'b1;
            end
            offset = offset + 1'b1;
            case (phase)
                PH_TYPE:
                begin
                    rec_kind = it.byte_value;
                    phase = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    hdr_len = {it.byte_value, 8'h00};
                    phase = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    hdr_len[7:0] = it.byte_value;
                    phase = PH_ADR_HI;
                end
                PH_ADR_HI:
                begin
                    addr_hi = it.byte_value;
                    phase = PH_ADR_LO;
                end
                PH_ADR_LO:
                begin
                    addr = {addr_hi, it.byte_value};
                    done = 1'b1;
                    if (rec_kind == KIND_DATA)
                    begin
                        room = (offset >= size_limit) ? '0 : size_limit - offset;
                        if ({1'b0, addr} + {1'b0, hdr_len} > ADDR_LIMIT)
                            st = ST_WRAP;
                        else if (hits_span(addr, hdr_len, MAILBOX_LO, MAILBOX_HI))
                            st = ST_MAILBOX;
                        else if (hits_span(addr, hdr_len, LOADER_LO, LOADER_HI))
                            st = ST_LOADER;
                        else if (hdr_len > room)
                            st = ST_BADLEN;
                        else
                        begin
                            done = 1'b0;
                            if (hdr_len == 16'd0)
                                accept_record();
                            else
                            begin
                                payload_left = hdr_len;
                                phase = PH_PAYLOAD;
                            end
                        end
                    end
                    else if (rec_kind != KIND_END)
                        st = ST_BADREC;
                    else if (rec_count == '0)
                        st = ST_MISSING;
                    else if (addr >= MAILBOX_LO && addr <= MAILBOX_HI)
                        st = ST_MAILBOX;
                    else if (addr >= LOADER_LO && addr <= LOADER_HI)
                        st = ST_LOADER;
                    else
                        st = ST_OK;
                end
                PH_PAYLOAD:
                begin
                    payload_left = payload_left - 1'b1;
                    if (payload_left == 16'd0)
                        accept_record();
                end
                default:
                    phase = PH_TYPE;
            endcase
            // out of bytes with the file still open
            if (!done && offset >= size_limit)
            begin
                done = 1'b1;
                st = ST_TRUNC;
            end
            if (done)
                r = close(st, addr);
            return done;
        endfunction

        function void note_item(item_t it);
            result_t r;
            if (parse_byte(it, r))
                pending.push_back(r);
        endfunction

        function void report_field(string name, logic [23:0] want, logic [23:0] got);
            if (want !== got)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                report_field("status", 24'(want.status), 24'(got.status));
                report_field("entry_addr", 24'(want.entry_addr), 24'(got.entry_addr));
                report_field("payload_total", want.payload_total, got.payload_total);
                report_field("consumed_total", want.consumed_total, got.consumed_total);
                report_field("record_total", want.record_total, got.record_total);
            end
            else
            begin
                matched++;
                status_hits[want.status]++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_ready;
    item_t             item = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    result_t           result;
    logic              cfg_we = 1'b0;
    logic [SIZE_W-1:0] cfg_wdata = '0;

    verdict_board board;
    item_t        byte_plan[$];
    int           burst_left = 0;
    int           quiet = 0;
    int           byte_xfers = 0;
    int           size_writes = 0;
    rx_mode_e     rx_mode = RX_OPEN;
    int           rx_cycle = 0;

    load_record_stream_validator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver switches between randomly chosen stall patterns
    always @(posedge clk)
    begin
        if (rx_cycle % 50 == 0)
            rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_cycle++;
        case (rx_mode)
            RX_OPEN:     result_ready <= 1'b1;
            RX_MOSTLY:   result_ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: result_ready <= (rx_cycle % 5 == 0);
            default:     result_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // mid-cycle sampling: everything is stable until the next rising edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                board.set_size(cfg_wdata);
            if (item_valid && item_ready)
            begin
                board.note_item(item);
                byte_xfers++;
            end
            if (result_valid && result_ready)
                board.check_result(result);
            if (cfg_we || (item_valid && item_ready) || (result_valid && result_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        byte_plan.push_back(item_t'({1'b0, b}));
    endtask

    task automatic push_fail();
        byte_plan.push_back(item_t'({1'b1, 8'($urandom)}));
    endtask

    task automatic push_header(input logic [7:0] kind_byte, input logic [15:0] len,
                               input logic [15:0] addr);
        push_byte(kind_byte);
        push_byte(len[15:8]);
        push_byte(len[7:0]);
        push_byte(addr[15:8]);
        push_byte(addr[7:0]);
    endtask

    // mostly well-formed files; a bad record ends the file at or after its header
    task automatic build_file(input bit allow_badlen);
        int          n_data;
        int          len;
        fault_e      fault;
        logic [15:0] addr;
        logic [7:0]  kind_byte;
        n_data = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
        repeat (n_data)
        begin
            fault = ($urandom_range(0, 9) == 0) ? fault_e'($urandom_range(1, 7)) : F_NONE;
            if (fault == F_BADLEN && !allow_badlen)
                fault = F_NONE;
            len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(13, 48);
            addr = 16'($urandom_range(0, 16'hFDFF - len));
            kind_byte = KIND_DATA;
            case (fault)
                F_WRAP:
                begin
                    addr = 16'hFFFF - 16'($urandom_range(0, 3));
                    len = $urandom_range(5, 9);
                end
                F_WRAP_FULL:
                begin
                    addr = 16'($urandom_range(1, 16'hFFFF));
                    len = 16'hFFFF;
                end
                F_MAILBOX:
                begin
                    addr = MAILBOX_LO - 16'd4 + 16'($urandom_range(0, 8));
                    len = $urandom_range(1, 4);
                end
                F_LOADER:
                begin
                    addr = LOADER_LO - 16'd8 + 16'($urandom_range(0, 16'h108));
                    len = $urandom_range(1, 8);
                end
                F_BADLEN:
                begin
                    addr = 16'($urandom_range(0, 16'h1000));
                    len = $urandom_range(64, 4000);
                end
                F_BADTYPE:
                    kind_byte = 8'($urandom_range(1, 254));
                default:
                    ;
            endcase
            push_header(kind_byte, 16'(len), addr);
            if (fault == F_READFAIL)
            begin
                repeat ($urandom_range(0, len))
                    push_byte(8'($urandom));
                push_fail();
                return;
            end
            if (fault != F_NONE)
                return;
            repeat (len)
                push_byte(8'($urandom));
        end
        case ($urandom_range(0, 11))
            0:       addr = 16'h0000;
            1:       addr = 16'hFFFF;
            2:       addr = MAILBOX_LO + 16'($urandom_range(0, 2));
            3:       addr = LOADER_LO + 16'($urandom_range(0, 255));
            4:       addr = MAILBOX_LO - 16'd1;
            5:       addr = MAILBOX_HI + 16'd1;
            6:       addr = LOADER_LO - 16'd1;
            default: addr = 16'($urandom_range(0, 16'hFDFF));
        endcase
        push_header(KIND_END, 16'($urandom), addr);
    endtask

    task automatic fill_files(input int target, input bit allow_badlen);
        while (byte_plan.size() < target)
        begin
            // stray bytes between files
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3))
                    push_byte(8'($urandom));
            build_file(allow_badlen);
        end
    endtask

    task automatic flush_items(input int count);
        int sent;
        bit taken;
        sent = 0;
        while (sent < count)
        begin
            if (burst_left == 0)
            begin
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 12);
            end
            item <= byte_plan.pop_front();
            item_valid <= 1'b1;
            taken = 1'b0;
            while (!taken)
            begin
                @(negedge clk);
                taken = item_ready;
                @(posedge clk);
            end
            sent++;
            burst_left--;
            if (burst_left == 0 || sent == count)
                item_valid <= 1'b0;
        end
        // next call starts with a gap so valid never drops and rises in one step
        burst_left = 0;
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] v);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        size_writes++;
    endtask

    initial
    begin
        int n;
        int cut;
        board = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // size is zero out of reset, so the first byte already lies past the end
        push_byte(8'hA5);
        flush_items(byte_plan.size());

        write_size('1);
        push_fail();
        push_header(KIND_DATA, 16'hFFFF, 16'hFFFF);
        push_header(8'h01, 16'h0000, 16'h0000);
        // empty data record then an end record at the top address
        push_header(KIND_DATA, 16'h0000, 16'h1234);
        push_header(KIND_END, 16'h0000, 16'hFFFF);
        flush_items(byte_plan.size());

        // header cut short by the size
        write_size(24'd3);
        repeat (3)
            push_byte(KIND_DATA);
        flush_items(byte_plan.size());

        write_size('1);
        fill_files(100, 1'b0);
        flush_items(byte_plan.size());

        repeat (3)
        begin
            write_size(24'($urandom_range(16, 160)));
            fill_files(40, 1'b1);
            flush_items(byte_plan.size());
        end

        // sizes fitted around one file, some changed part way through
        repeat (8)
        begin
            build_file(1'b1);
            n = byte_plan.size();
            case ($urandom_range(0, 3))
                0:
                begin
                    write_size(24'(n));
                    flush_items(n);
                end
                1:
                begin
                    write_size(24'(n - 1));
                    flush_items(n);
                end
                2:
                begin
                    write_size(24'(n + $urandom_range(1, 3)));
                    flush_items(n);
                end
                default:
                begin
                    write_size('1);
                    cut = $urandom_range(1, n - 1);
                    flush_items(cut);
                    write_size(24'($urandom_range(0, n)));
                    flush_items(n - cut);
                end
            endcase
        end

        write_size('0);
        repeat (4)
            push_byte(8'($urandom));
        flush_items(byte_plan.size());

        write_size(24'd1);
        repeat (4)
            push_byte(8'($urandom));
        push_fail();
        flush_items(byte_plan.size());

        write_size('1);
        fill_files(60, 1'b0);
        flush_items(byte_plan.size());

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d byte transfers, %0d file size writes, %0d verdicts matched",
                 byte_xfers, size_writes, board.matched);
        $display({"verdicts: ok %0d trunc %0d wrap %0d mailbox %0d loader %0d",
                  " bad length %0d bad record %0d missing data %0d"},
                 board.status_hits[ST_OK], board.status_hits[ST_TRUNC],
                 board.status_hits[ST_WRAP], board.status_hits[ST_MAILBOX],
                 board.status_hits[ST_LOADER], board.status_hits[ST_BADLEN],
                 board.status_hits[ST_BADREC], board.status_hits[ST_MISSING]);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: load_record_stream_validator.f
rtl/core/lrsv_pkg.sv
rtl/core/lrsv_step.sv
rtl/core/load_record_stream_validator.sv
bench/load_record_stream_validator_test.sv
